// ===== rtl/colored_ticket_mutex_arbiter_core_assert.svh =====
// Assertion macros shared by the arbiter RTL.
`ifndef COLORED_TICKET_MUTEX_ARBITER_CORE_ASSERT_SVH
`define COLORED_TICKET_MUTEX_ARBITER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define CTMA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define CTMA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define CTMA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CTMA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/ctma_pkg.sv =====
package ctma_pkg;

   localparam int REQUESTERS = 8;
   localparam int ENTRY_W    = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
   localparam int VALID_DEPTH = 1 << ENTRY_W;

   localparam int TICKET_W = 8;
   localparam logic [TICKET_W-1:0] TICKET_MAX = 8'd255;

   // Request kinds.
   localparam logic [1:0] REQ_TAKE  = 2'd0;
   localparam logic [1:0] REQ_ENTER = 2'd1;
   localparam logic [1:0] REQ_LEAVE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_HELD = 2'd1;
   localparam logic [1:0] STAT_NONE = 2'd2;
   localparam logic [1:0] STAT_SAT  = 2'd3;

   typedef struct packed {
      logic                color;
      logic [TICKET_W-1:0] ticket;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

// ===== rtl/ctma_ram.sv =====
module ctma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/colored_ticket_mutex_arbiter_core.sv =====
// Black-white bakery arbiter for a shared critical section, one request at a time.
// Request channel: req_tuser carries the request kind (take, enter, leave) and
// req_tdata the requester index. Response channel: one response per request,
// with the grant flag, the requester's ticket and color in rsp_tdata and the
// status code in rsp_tuser.
// Sequence: a take or an enter that proceeds looks up the requester's own entry,
// makes one pass over all REQUESTERS entries of the ticket memory at one entry per
// cycle, updates, and then loads the response register as soon as it is free.
// Refused requests, leaves and unknown kinds skip the pass and the update; an
// out-of-range index skips the lookup as well. The single read port of the ticket
// memory, shared by the lookup and the scan, keeps these steps in sequence.
// req_tready is high only while idle, and the block returns to idle as the
// response register is loaded, so a new request is not taken before the last one
// has been answered.
// A finished response waits in its register while the next request is taken;
// if the receiver stalls longer, the sequencer holds the following response
// until the register frees up.
// Reset clears all tickets, sets the global color to white and empties the
// response register. The memory is not swept: per-entry valid bits make
// unwritten entries read as no ticket, white.
module colored_ticket_mutex_arbiter_core
   import ctma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] requester, [7:3] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] granted, [8:1] ticket, [9] ticket_color, [15:10] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

`include "colored_ticket_mutex_arbiter_core_assert.svh"

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SELF   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam logic [ENTRY_W-1:0] LAST_IDX = ENTRY_W'(REQUESTERS - 1);

   logic [2:0]          state_ff, state_in;
   logic [1:0]          kind_ff, kind_in;
   logic [ENTRY_W-1:0]  who_ff, who_in;
   logic [ENTRY_W-1:0]  idx_ff, idx_in;
   logic [TICKET_W-1:0] my_ticket_ff, my_ticket_in;
   logic                my_color_ff, my_color_in;
   logic [TICKET_W-1:0] best_ff, best_in;
   logic                ok_ff, ok_in;
   logic                cur_color_ff, cur_color_in;
   logic [VALID_DEPTH-1:0] valid_ff, valid_in;
   logic                rd_valid_ff;

   logic                res_granted_ff, res_granted_in;
   logic [TICKET_W-1:0] res_ticket_ff, res_ticket_in;
   logic                res_color_ff, res_color_in;
   logic [1:0]          res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;

   logic                req_fire;
   logic                in_range;
   logic [ENTRY_W-1:0]  req_who;
   logic [ENTRY_W-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] ram_q;
   entry_type           rd_entry;
   logic                wr_en;
   logic [ENTRY_W-1:0]  wr_addr;
   entry_type           wr_entry;
   logic                rsp_free;
   logic                entry_ok;
   logic [TICKET_W-1:0] new_ticket;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_range   = (int'(req_tdata[2:0]) < REQUESTERS);
   assign req_who    = ENTRY_W'(req_tdata[2:0]);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   ctma_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (REQUESTERS)
   ) u_ticket_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Entries never written read as no ticket, white.
   assign rd_entry = rd_valid_ff ? entry_type'(ram_q) : '0;

   // Read address: own entry on acceptance, then entry 0, then one ahead of
   // the entry being examined.
   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = req_who;
         S_SELF:  rd_addr = '0;
         default: rd_addr = idx_ff + 1'b1;
      endcase
   end

   // Judgment of one scanned entry against the requester, for a try-enter.
   always_comb begin
      entry_ok = 1'b1;
      if ((idx_ff != who_ff) && (rd_entry.ticket != '0)) begin
         if (rd_entry.color == my_color_ff) begin
            entry_ok = (rd_entry.ticket > my_ticket_ff) ||
                       ((rd_entry.ticket == my_ticket_ff) && (idx_ff > who_ff));
         end else begin
            entry_ok = (my_color_ff != cur_color_ff);
         end
      end
   end

   assign new_ticket = (best_ff == TICKET_MAX) ? TICKET_MAX : best_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      who_in         = who_ff;
      idx_in         = idx_ff;
      my_ticket_in   = my_ticket_ff;
      my_color_in    = my_color_ff;
      best_in        = best_ff;
      ok_in          = ok_ff;
      cur_color_in   = cur_color_ff;
      valid_in       = valid_ff;
      res_granted_in = res_granted_ff;
      res_ticket_in  = res_ticket_ff;
      res_color_in   = res_color_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      wr_en          = 1'b0;
      wr_addr        = who_ff;
      wr_entry       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in = req_tuser;
               who_in  = req_who;
               if (in_range) begin
                  state_in = S_SELF;
               end else begin
                  res_granted_in = 1'b0;
                  res_ticket_in  = '0;
                  res_color_in   = 1'b0;
                  res_status_in  = STAT_NONE;
                  state_in       = S_FINISH;
               end
            end
         end
         S_SELF: begin
            my_ticket_in   = rd_entry.ticket;
            my_color_in    = rd_entry.color;
            res_granted_in = 1'b0;
            res_ticket_in  = rd_entry.ticket;
            res_color_in   = rd_entry.color;
            res_status_in  = STAT_OK;
            idx_in         = '0;
            best_in        = '0;
            ok_in          = 1'b1;
            state_in       = S_FINISH;
            unique case (kind_ff)
               REQ_TAKE: begin
                  if (rd_entry.ticket != '0) begin
                     res_status_in = STAT_HELD;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               REQ_ENTER: begin
                  if (rd_entry.ticket == '0) begin
                     res_status_in = STAT_NONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               REQ_LEAVE: begin
                  if (rd_entry.ticket == '0) begin
                     res_status_in = STAT_NONE;
                  end else begin
                     // The color stays with the entry; only the ticket goes.
                     wr_en           = 1'b1;
                     wr_entry.color  = rd_entry.color;
                     wr_entry.ticket = '0;
                     valid_in[who_ff] = 1'b1;
                     cur_color_in    = ~rd_entry.color;
                     res_ticket_in   = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (kind_ff == REQ_TAKE) begin
               if ((rd_entry.color == cur_color_ff) && (rd_entry.ticket > best_ff)) begin
                  best_in = rd_entry.ticket;
               end
            end else begin
               ok_in = ok_ff && entry_ok;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (kind_ff == REQ_TAKE) begin
               wr_en            = 1'b1;
               wr_entry.color   = cur_color_ff;
               wr_entry.ticket  = new_ticket;
               valid_in[who_ff] = 1'b1;
               res_ticket_in    = new_ticket;
               res_color_in     = cur_color_ff;
               res_status_in    = (best_ff == TICKET_MAX) ? STAT_SAT : STAT_OK;
            end else begin
               res_granted_in = ok_ff;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, res_color_ff, res_ticket_ff, res_granted_ff};
               rsp_user_in  = res_status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_color_ff <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_color_ff <= cur_color_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      who_ff         <= who_in;
      idx_ff         <= idx_in;
      my_ticket_ff   <= my_ticket_in;
      my_color_ff    <= my_color_in;
      best_ff        <= best_in;
      ok_ff          <= ok_in;
      res_granted_ff <= res_granted_in;
      res_ticket_ff  <= res_ticket_in;
      res_color_ff   <= res_color_in;
      res_status_ff  <= res_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `CTMA_ASSERT_NXT(a_busy_after_request, clock, reset, req_fire, !req_tready)
   `CTMA_ASSERT_IMP(a_grant_is_ok, clock, reset, rsp_tvalid && rsp_tdata[0],
                    (rsp_tuser == STAT_OK) && (rsp_tdata[8:1] != '0))
   `CTMA_ASSERT_IMP(a_take_writes_ticket, clock, reset, wr_en && (state_ff == S_UPDATE),
                    wr_entry.ticket != '0)
   `CTMA_ASSERT_IMP(a_update_after_full_scan, clock, reset, state_ff == S_UPDATE,
                    (idx_ff == LAST_IDX + 1'b1) && (kind_ff == REQ_TAKE || kind_ff == REQ_ENTER))

endmodule

// ===== tb/ticket_grant_checker.sv =====
`timescale 1ns / 100ps

module ticket_grant_checker
   import ctma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          errors,
   output int          outstanding
);

   typedef struct packed {
      logic                granted;
      logic [TICKET_W-1:0] ticket;
      logic                color;
      logic [1:0]          status;
   } grant_reply_type;

   localparam int MAX_PRINTED = 40;

   // Shadow of the arbiter state.
   logic [TICKET_W-1:0] held_ticket [REQUESTERS];
   logic                held_color  [REQUESTERS];
   logic                global_color;

   grant_reply_type expected_replies [$];
   int              mismatch_count = 0;
   int              pending_count  = 0;

   assign errors      = mismatch_count;
   assign outstanding = pending_count;

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic logic [TICKET_W-1:0] highest_ticket(input logic col);
      logic [TICKET_W-1:0] best;
      best = '0;
      for (int k = 0; k < REQUESTERS; k++)
         if (held_color[k] == col && held_ticket[k] > best)
            best = held_ticket[k];
      return best;
   endfunction

   // A requester may enter when no other ticket holder goes ahead of it.
   function automatic logic entry_allowed(input int who);
      logic ok;
      for (int k = 0; k < REQUESTERS; k++) begin
         if (k == who || held_ticket[k] == 0)
            continue;
         if (held_color[k] == held_color[who])
            ok = (held_ticket[k] > held_ticket[who]) ||
                 (held_ticket[k] == held_ticket[who] && k > who);
         else
            ok = (held_color[who] != global_color);
         if (!ok)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic grant_reply_type advance_arbiter(input logic [1:0] kind,
                                                       input logic [2:0] who);
      grant_reply_type reply;
      logic [TICKET_W-1:0] top_ticket;
      reply        = '0;
      reply.status = STAT_OK;
      if (who >= REQUESTERS) begin
         reply.status = STAT_NONE;
         return reply;
      end
      case (kind)
         REQ_TAKE: begin
            if (held_ticket[who] != 0) begin
               reply.status = STAT_HELD;
            end else begin
               held_color[who] = global_color;
               top_ticket      = highest_ticket(global_color);
               if (top_ticket == TICKET_MAX) begin
                  held_ticket[who] = TICKET_MAX;
                  reply.status     = STAT_SAT;
               end else begin
                  held_ticket[who] = top_ticket + 1'b1;
               end
            end
         end
         REQ_ENTER: begin
            if (held_ticket[who] == 0)
               reply.status = STAT_NONE;
            else
               reply.granted = entry_allowed(who);
         end
         REQ_LEAVE: begin
            if (held_ticket[who] == 0) begin
               reply.status = STAT_NONE;
            end else begin
               global_color     = ~held_color[who];
               held_ticket[who] = '0;
            end
         end
         default: ;
      endcase
      reply.ticket = held_ticket[who];
      reply.color  = held_color[who];
      return reply;
   endfunction

   always @(posedge clock) begin
      grant_reply_type want;
      grant_reply_type got;
      if (reset) begin
         for (int k = 0; k < REQUESTERS; k++) begin
            held_ticket[k] = '0;
            held_color[k]  = 1'b0;
         end
         global_color = 1'b0;
         expected_replies.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_replies.push_back(advance_arbiter(req_tuser, req_tdata[2:0]));
         if (rsp_tvalid && rsp_tready) begin
            got.granted = rsp_tdata[0];
            got.ticket  = rsp_tdata[8:1];
            got.color   = rsp_tdata[9];
            got.status  = rsp_tuser;
            if (expected_replies.size() == 0) begin
               report_mismatch("response with no request waiting", rsp_tdata, 0);
            end else begin
               want = expected_replies.pop_front();
               if (got.granted != want.granted)
                  report_mismatch("granted", got.granted, want.granted);
               if (got.ticket != want.ticket)
                  report_mismatch("ticket", got.ticket, want.ticket);
               if (got.color != want.color)
                  report_mismatch("ticket_color", got.color, want.color);
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
      end
      pending_count <= expected_replies.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import ctma_pkg::*;
();

   // Request kind with no defined action; the block must leave state alone.
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int CLIMB_ROUNDS   = 258;
   localparam int RANDOM_ITEMS   = 460;
   localparam int DRAIN_CYCLES   = 30;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          errors;
   int          outstanding;

   logic [REQUESTERS-1:0] holds = '0;
   logic no_gaps = 1'b0;
   int   take_count  = 0;
   int   enter_count = 0;
   int   leave_count = 0;
   int   other_count = 0;

   colored_ticket_mutex_arbiter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ticket_grant_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   function automatic int pick_free();
      int start;
      start = $urandom_range(0, REQUESTERS - 1);
      for (int i = 0; i < REQUESTERS; i++)
         if (!holds[(start + i) % REQUESTERS])
            return (start + i) % REQUESTERS;
      return -1;
   endfunction

   function automatic int pick_holder();
      int start;
      start = $urandom_range(0, REQUESTERS - 1);
      for (int i = 0; i < REQUESTERS; i++)
         if (holds[(start + i) % REQUESTERS])
            return (start + i) % REQUESTERS;
      return -1;
   endfunction

   // Called at a falling edge; returns at a falling edge after the request is taken.
   task automatic issue(input logic [1:0] kind, input int who);
      int gap;
      req_tuser  <= kind;
      req_tdata  <= {5'b00000, who[2:0]};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      case (kind)
         REQ_TAKE: begin
            holds[who] = 1'b1;
            take_count++;
         end
         REQ_ENTER: enter_count++;
         REQ_LEAVE: begin
            holds[who] = 1'b0;
            leave_count++;
         end
         default: other_count++;
      endcase
      if ($urandom_range(0, 79) == 0)
         no_gaps = ~no_gaps;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Requests that change no state: enters by anyone, repeated takes,
   // leaves without a ticket and the undefined kind.
   task automatic noise_item();
      int r;
      int pick;
      r = $urandom_range(0, 3);
      case (r)
         0: issue(REQ_ENTER, $urandom_range(0, REQUESTERS - 1));
         1: begin
            pick = pick_holder();
            if (pick >= 0)
               issue(REQ_TAKE, pick);
            else
               issue(REQ_ENTER, $urandom_range(0, REQUESTERS - 1));
         end
         2: issue(REQ_UNKNOWN, $urandom_range(0, REQUESTERS - 1));
         default: begin
            pick = pick_free();
            if (pick >= 0)
               issue(REQ_LEAVE, pick);
            else
               issue(REQ_UNKNOWN, $urandom_range(0, REQUESTERS - 1));
         end
      endcase
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 5) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // Ends the run if neither channel moves for too long.
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int a;
      int b;
      int c;
      int lead;
      int trail;
      int fresh;
      int r;
      int f;
      int h;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening, starting from an empty arbiter with white current.
      issue(REQ_ENTER, 0);     // enter without a ticket
      issue(REQ_LEAVE, 7);     // leave without a ticket
      issue(REQ_UNKNOWN, 5);
      issue(REQ_TAKE, 0);
      issue(REQ_TAKE, 0);      // second take is refused
      issue(REQ_TAKE, 7);
      issue(REQ_ENTER, 7);     // refused, requester 0 is ahead
      issue(REQ_ENTER, 0);     // granted
      issue(REQ_TAKE, 3);
      issue(REQ_LEAVE, 0);     // current color turns black
      issue(REQ_TAKE, 5);
      issue(REQ_ENTER, 5);     // refused, white holders still ahead
      issue(REQ_ENTER, 7);     // granted, white is no longer current
      issue(REQ_UNKNOWN, 7);
      issue(REQ_LEAVE, 7);
      issue(REQ_LEAVE, 3);     // leave without having been granted
      issue(REQ_ENTER, 5);
      issue(REQ_TAKE, 2);
      issue(REQ_TAKE, 4);
      issue(REQ_ENTER, 4);
      issue(REQ_LEAVE, 5);
      issue(REQ_LEAVE, 2);
      issue(REQ_LEAVE, 4);

      // Ticket climb: one holder of each color is kept at all times, and each
      // round replaces both with fresh takes, so both colors' largest tickets
      // rise by one per round until they saturate.
      a = pick_free();
      issue(REQ_TAKE, a);
      b = pick_free();
      issue(REQ_TAKE, b);
      issue(REQ_LEAVE, a);
      c = pick_free();
      issue(REQ_TAKE, c);
      lead  = c;
      trail = b;
      repeat (CLIMB_ROUNDS) begin
         fresh = pick_free();
         issue(REQ_TAKE, fresh);
         if ($urandom_range(0, 4) == 0)
            noise_item();
         issue(REQ_LEAVE, lead);
         lead = fresh;
         fresh = pick_free();
         issue(REQ_TAKE, fresh);
         if ($urandom_range(0, 4) == 0)
            noise_item();
         issue(REQ_LEAVE, trail);
         trail = fresh;
         if ($urandom_range(0, 2) == 0)
            noise_item();
      end
      for (int i = 0; i < REQUESTERS; i++)
         if (holds[i])
            issue(REQ_LEAVE, i);

      // Random mix with tickets starting small again.
      repeat (RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         f = pick_free();
         h = pick_holder();
         if (r < 35 && f >= 0)
            issue(REQ_TAKE, f);
         else if (r < 65 && h >= 0)
            issue(REQ_ENTER, h);
         else if (r < 85 && h >= 0)
            issue(REQ_LEAVE, h);
         else
            noise_item();
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d takes, %0d enters, %0d leaves and %0d undefined requests,",
               take_count, enter_count, leave_count, other_count);
      $display("including a %0d-round ticket climb into saturation.", CLIMB_ROUNDS);
      if (errors == 0 && outstanding == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
